// ===== rtl/affine_point_transform_2d_core_macros.svh =====
// Assertion macros for the affine point transform checker.
`ifndef AFFINE_POINT_TRANSFORM_2D_CORE_MACROS_SVH
`define AFFINE_POINT_TRANSFORM_2D_CORE_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define APT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication.");

// Next-cycle implication under an active-low reset.
`define APT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication.");

`endif

// ===== rtl/apt_pkg.sv =====
// Shared types, constants and tables for the affine point transform.
`default_nettype none

package apt_pkg;

    localparam int DEF_FRAC_BITS    = 16;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 32;
    localparam int SCALE_W    = 16;
    localparam int ANGLE_W    = 16;
    localparam int TRIG_W     = 33;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30  = 33'sd1073741824;

    localparam logic [ANGLE_W-1:0] ANG_360 = 16'd36000;
    localparam logic [ANGLE_W-1:0] ANG_270 = 16'd27000;
    localparam logic [ANGLE_W-1:0] ANG_180 = 16'd18000;
    localparam logic [ANGLE_W-1:0] ANG_90  = 16'd9000;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_X     = 3'd0,
        CFG_SCALE_Y     = 3'd1,
        CFG_ROT_ANGLE   = 3'd2,
        CFG_TRANSLATE_X = 3'd3,
        CFG_TRANSLATE_Y = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_INIT,
        CS_ROT,
        CS_MUL,
        CS_STORE
    } t_coef_state;

    typedef enum logic [1:0] {
        COEF_XX,
        COEF_XY,
        COEF_YX,
        COEF_YY
    } t_coef_sel;

    typedef struct packed {
        logic [COORD_W-1:0] xx;
        logic [COORD_W-1:0] xy;
        logic [COORD_W-1:0] yx;
        logic [COORD_W-1:0] yy;
    } t_coefs;

    // Arc tangent of 2^-i in units of 1/65536 of a hundredth of a degree.
    function automatic logic signed [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd294912000;
            5'd1:    v = 32'sd174096719;
            5'd2:    v = 32'sd91987925;
            5'd3:    v = 32'sd46694507;
            5'd4:    v = 32'sd23437865;
            5'd5:    v = 32'sd11730358;
            5'd6:    v = 32'sd5866610;
            5'd7:    v = 32'sd2933484;
            5'd8:    v = 32'sd1466764;
            5'd9:    v = 32'sd733385;
            5'd10:   v = 32'sd366693;
            5'd11:   v = 32'sd183347;
            5'd12:   v = 32'sd91674;
            5'd13:   v = 32'sd45837;
            5'd14:   v = 32'sd22918;
            5'd15:   v = 32'sd11459;
            5'd16:   v = 32'sd5730;
            5'd17:   v = 32'sd2865;
            5'd18:   v = 32'sd1432;
            5'd19:   v = 32'sd716;
            5'd20:   v = 32'sd358;
            5'd21:   v = 32'sd179;
            5'd22:   v = 32'sd90;
            5'd23:   v = 32'sd45;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/affine_point_transform_2d_core.sv =====
// Top level of the 2D scale, rotate and translate point transform.
//
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_point_x, i_point_y
// out       output     o_out_valid / i_out_ready  o_out_x, o_out_y, o_clipped
// cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One point is accepted per cycle while o_in_ready is high; its result passes
// through the input, product, sum and output registers. A register write
// recomputes the coefficients, skipping the CORDIC rotation for multiples of
// 90 degrees, then runs the shared scale multiplier, with o_in_ready low meanwhile.
// Reset is synchronous and leaves the identity transform in place.
// A stalled output holds its transaction while the pipeline keeps filling.
`default_nettype none

module affine_point_transform_2d_core #(
    parameter int FRAC_BITS    = apt_pkg::DEF_FRAC_BITS,
    parameter int CORDIC_STEPS = apt_pkg::DEF_CORDIC_STEPS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [apt_pkg::COORD_W-1:0]    i_point_x,
    input  logic signed [apt_pkg::COORD_W-1:0]    i_point_y,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [apt_pkg::COORD_W-1:0]    o_out_x,
    output logic signed [apt_pkg::COORD_W-1:0]    o_out_y,
    output logic                                  o_clipped,
    input  logic                                  i_cfg_we,
    input  logic        [apt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [apt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import apt_pkg::*;

    logic signed [SCALE_W-1:0] r_scale_x, r_scale_y;
    logic        [ANGLE_W-1:0] r_angle;
    logic signed [COORD_W-1:0] r_translate_x, r_translate_y;

    logic   cfg_start;
    logic   coef_busy;
    logic   dp_ready;
    t_coefs coefs;

    always_comb begin
        cfg_start = 1'b0;
        unique case (i_cfg_idx)
            CFG_SCALE_X, CFG_SCALE_Y, CFG_ROT_ANGLE,
            CFG_TRANSLATE_X, CFG_TRANSLATE_Y: cfg_start = i_cfg_we;
            default: cfg_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x     <= 16'sd256;
            r_scale_y     <= 16'sd256;
            r_angle       <= '0;
            r_translate_x <= '0;
            r_translate_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE_X:     r_scale_x     <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:     r_scale_y     <= i_cfg_data[SCALE_W-1:0];
                CFG_ROT_ANGLE:   r_angle       <= i_cfg_data[ANGLE_W-1:0];
                CFG_TRANSLATE_X: r_translate_x <= i_cfg_data[COORD_W-1:0];
                CFG_TRANSLATE_Y: r_translate_y <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    apt_coef_unit #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_coef (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cfg_start),
        .i_scale_x (r_scale_x),
        .i_scale_y (r_scale_y),
        .i_angle   (r_angle),
        .o_busy    (coef_busy),
        .o_coefs   (coefs)
    );

    assign o_in_ready = dp_ready && !coef_busy && !cfg_start;

    apt_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (i_in_valid && o_in_ready),
        .o_ready       (dp_ready),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_coefs       (coefs),
        .i_translate_x (r_translate_x),
        .i_translate_y (r_translate_y),
        .o_valid       (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_clipped     (o_clipped)
    );

endmodule

`default_nettype wire

// ===== rtl/apt_coef_unit.sv =====
// Coefficient unit: iterative CORDIC followed by shared scale multiplies.
`default_nettype none

module apt_coef_unit #(
    parameter int FRAC_BITS    = apt_pkg::DEF_FRAC_BITS,
    parameter int CORDIC_STEPS = apt_pkg::DEF_CORDIC_STEPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [apt_pkg::SCALE_W-1:0]  i_scale_x,
    input  logic signed [apt_pkg::SCALE_W-1:0]  i_scale_y,
    input  logic        [apt_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_busy,
    output apt_pkg::t_coefs                     o_coefs
);
    import apt_pkg::*;

    localparam int PROD_W = SCALE_W + TRIG_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int CSH    = 38 - FRAC_BITS;
    localparam int EXT_W  = 40;
    localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(CORDIC_STEPS - 1);

    t_coef_state r_state, n_state;
    t_coef_sel   r_sel, n_sel;
    logic [ATAN_IDX_W-1:0]     r_i, n_i;
    logic signed [TRIG_W-1:0]  r_x, n_x;
    logic signed [TRIG_W-1:0]  r_y, n_y;
    logic signed [31:0]        r_z, n_z;
    logic                      r_neg, n_neg;
    logic signed [PROD_W-1:0]  r_prod;
    t_coefs                    r_coefs;

    logic [ANGLE_W-1:0]        a_mod;
    logic signed [16:0]        a_fold;
    logic                      fold_neg;
    logic signed [TRIG_W-1:0]  dx, dy;
    logic signed [TRIG_W-1:0]  trig_base, trig;
    logic signed [SCALE_W-1:0] scale_sel;
    logic signed [RND_W-1:0]   rnd_sum;
    logic signed [EXT_W-1:0]   rnd_ext;
    logic [COORD_W-1:0]        coef_sat;

    always_comb begin
        a_mod = (i_angle >= ANG_360) ? (i_angle - ANG_360) : i_angle;
        fold_neg = 1'b0;
        if (a_mod > ANG_270) begin
            a_fold = 17'(a_mod) - 17'(ANG_360);
        end else if (a_mod > ANG_90) begin
            a_fold = 17'(a_mod) - 17'(ANG_180);
            fold_neg = 1'b1;
        end else begin
            a_fold = 17'(a_mod);
        end
    end

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;

    always_comb begin
        trig_base = ((r_sel == COEF_XX) || (r_sel == COEF_YY)) ? r_x : r_y;
        trig = (r_neg ^ (r_sel == COEF_YX)) ? -trig_base : trig_base;
        scale_sel = ((r_sel == COEF_XX) || (r_sel == COEF_XY)) ? i_scale_x : i_scale_y;
    end

    always_comb begin
        rnd_sum = RND_W'(r_prod) + (RND_W'(1) << (CSH - 1));
        rnd_ext = EXT_W'($signed(rnd_sum[RND_W-1:CSH]));
        if (rnd_ext > EXT_W'(SAT_MAX)) begin
            coef_sat = SAT_MAX;
        end else if (rnd_ext < EXT_W'(SAT_MIN)) begin
            coef_sat = SAT_MIN;
        end else begin
            coef_sat = rnd_ext[COORD_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_i     = r_i;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_neg   = r_neg;
        unique case (r_state)
            CS_IDLE: begin
            end
            CS_INIT: begin
                n_neg = fold_neg;
                n_i   = '0;
                n_sel = COEF_XX;
                n_z   = {a_fold[15:0], 16'h0000};
                if (a_fold == 17'sd0) begin
                    n_x = ONE_Q30;
                    n_y = '0;
                    n_state = CS_MUL;
                end else if (a_fold == 17'(ANG_90)) begin
                    n_x = '0;
                    n_y = ONE_Q30;
                    n_state = CS_MUL;
                end else begin
                    n_x = GAIN_Q30;
                    n_y = '0;
                    n_state = CS_ROT;
                end
            end
            CS_ROT: begin
                if (r_z >= 32'sd0) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - atan_lut(r_i);
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + atan_lut(r_i);
                end
                n_i = r_i + 1'b1;
                if (r_i == LAST_STEP) begin
                    n_state = CS_MUL;
                end
            end
            CS_MUL: begin
                n_state = CS_STORE;
            end
            CS_STORE: begin
                if (r_sel == COEF_YY) begin
                    n_state = CS_IDLE;
                end else begin
                    n_sel = t_coef_sel'(r_sel + 1'b1);
                    n_state = CS_MUL;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
        if (i_start) begin
            n_state = CS_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_sel   <= COEF_XX;
            r_i     <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_i     <= n_i;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        if (r_state == CS_MUL) begin
            r_prod <= scale_sel * trig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.xx <= COORD_W'(1) << FRAC_BITS;
            r_coefs.xy <= '0;
            r_coefs.yx <= '0;
            r_coefs.yy <= COORD_W'(1) << FRAC_BITS;
        end else if (r_state == CS_STORE) begin
            case (r_sel)
                COEF_XX: r_coefs.xx <= coef_sat;
                COEF_XY: r_coefs.xy <= coef_sat;
                COEF_YX: r_coefs.yx <= coef_sat;
                default: r_coefs.yy <= coef_sat;
            endcase
        end
    end

    assign o_busy  = (r_state != CS_IDLE);
    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

// ===== rtl/apt_datapath.sv =====
// Four-stage point pipeline: input, products, rounded sums, translate and saturate.
`default_nettype none

module apt_datapath #(
    parameter int FRAC_BITS = apt_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    output logic                                o_ready,
    input  logic signed [apt_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [apt_pkg::COORD_W-1:0]  i_point_y,
    input  apt_pkg::t_coefs                     i_coefs,
    input  logic signed [apt_pkg::COORD_W-1:0]  i_translate_x,
    input  logic signed [apt_pkg::COORD_W-1:0]  i_translate_y,
    output logic                                o_valid,
    input  logic                                i_out_ready,
    output logic signed [apt_pkg::COORD_W-1:0]  o_out_x,
    output logic signed [apt_pkg::COORD_W-1:0]  o_out_y,
    output logic                                o_clipped
);
    import apt_pkg::*;

    localparam int PROD_W = 2 * COORD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SH_W   = SUM_W - FRAC_BITS;
    localparam int TOT_W  = SH_W + 1;

    logic r1_v, r2_v, r3_v, r4_v;
    logic adv1, adv2, adv3, adv4;

    logic signed [COORD_W-1:0] r1_px, r1_py;
    logic signed [PROD_W-1:0]  r2_pxx, r2_pyx, r2_pxy, r2_pyy;
    logic signed [SH_W-1:0]    r3_sx, r3_sy;
    logic signed [COORD_W-1:0] r4_x, r4_y;
    logic                      r4_clip;

    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic signed [TOT_W-1:0]   tot_x, tot_y;
    logic signed [COORD_W-1:0] sat_x, sat_y;
    logic                      clip_x, clip_y;

    assign adv4 = !r4_v || i_out_ready;
    assign adv3 = !r3_v || adv4;
    assign adv2 = !r2_v || adv3;
    assign adv1 = !r1_v || adv2;
    assign o_ready = adv1;

    always_comb begin
        sum_x = SUM_W'(r2_pxx) + SUM_W'(r2_pyx) + (SUM_W'(1) << (FRAC_BITS - 1));
        sum_y = SUM_W'(r2_pxy) + SUM_W'(r2_pyy) + (SUM_W'(1) << (FRAC_BITS - 1));
    end

    always_comb begin
        tot_x = TOT_W'(r3_sx) + TOT_W'(i_translate_x);
        tot_y = TOT_W'(r3_sy) + TOT_W'(i_translate_y);
        clip_x = 1'b1;
        clip_y = 1'b1;
        if (tot_x > TOT_W'(SAT_MAX)) begin
            sat_x = SAT_MAX;
        end else if (tot_x < TOT_W'(SAT_MIN)) begin
            sat_x = SAT_MIN;
        end else begin
            sat_x = tot_x[COORD_W-1:0];
            clip_x = 1'b0;
        end
        if (tot_y > TOT_W'(SAT_MAX)) begin
            sat_y = SAT_MAX;
        end else if (tot_y < TOT_W'(SAT_MIN)) begin
            sat_y = SAT_MIN;
        end else begin
            sat_y = tot_y[COORD_W-1:0];
            clip_y = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (adv1) begin
                r1_v <= i_load;
            end
            if (adv2) begin
                r2_v <= r1_v;
            end
            if (adv3) begin
                r3_v <= r2_v;
            end
            if (adv4) begin
                r4_v <= r3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_load) begin
            r1_px <= i_point_x;
            r1_py <= i_point_y;
        end
        if (adv2 && r1_v) begin
            r2_pxx <= r1_px * $signed(i_coefs.xx);
            r2_pyx <= r1_py * $signed(i_coefs.yx);
            r2_pxy <= r1_px * $signed(i_coefs.xy);
            r2_pyy <= r1_py * $signed(i_coefs.yy);
        end
        if (adv3 && r2_v) begin
            r3_sx <= sum_x[SUM_W-1:FRAC_BITS];
            r3_sy <= sum_y[SUM_W-1:FRAC_BITS];
        end
        if (adv4 && r3_v) begin
            r4_x    <= sat_x;
            r4_y    <= sat_y;
            r4_clip <= clip_x || clip_y;
        end
    end

    assign o_valid   = r4_v;
    assign o_out_x   = r4_x;
    assign o_out_y   = r4_y;
    assign o_clipped = r4_clip;

endmodule

`default_nettype wire

// ===== rtl/apt_checker.sv =====
// Port-level checker for the affine point transform, bound to the top level.
`default_nettype none

`include "affine_point_transform_2d_core_macros.svh"

module apt_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_in_ready,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [apt_pkg::COORD_W-1:0]    o_out_x,
    input  logic signed [apt_pkg::COORD_W-1:0]    o_out_y,
    input  logic                                  o_clipped,
    input  logic                                  i_cfg_we,
    input  logic        [apt_pkg::CFG_IDX_W-1:0]  i_cfg_idx
);
    import apt_pkg::*;

    logic                   cfg_hit;
    logic                   any_sat;
    logic                   out_stall;
    logic [2*COORD_W:0]     out_word;

    assign cfg_hit = i_cfg_we && (i_cfg_idx <= CFG_TRANSLATE_Y);
    assign any_sat = (o_out_x == SAT_MAX) || (o_out_x == SAT_MIN) ||
                     (o_out_y == SAT_MAX) || (o_out_y == SAT_MIN);
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_word  = {o_out_x, o_out_y, o_clipped};

    `APT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_word))
    `APT_ASSERT_NOW(a_no_take_on_cfg, i_clk, i_rst_n, cfg_hit, !o_in_ready)
    `APT_ASSERT_NEXT(a_busy_after_cfg, i_clk, i_rst_n, cfg_hit, !o_in_ready)
    `APT_ASSERT_NOW(a_clip_is_limit, i_clk, i_rst_n, o_out_valid && o_clipped, any_sat)

endmodule

bind affine_point_transform_2d_core apt_checker u_apt_checker (.*);

`default_nettype wire
